>>> rtl/core/lpfp_pkg.sv
// Shared types and constants for the length-prefixed frame parser.
// No dependencies; imported by every module of the block.
package lpfp_pkg;

  // Header layout, in bytes from the start of a frame
  localparam int unsigned HDR_BYTES    = 14;
  localparam int unsigned HDR_CNT_W    = 4;
  localparam logic [HDR_CNT_W-1:0] HDR_MAGIC_POS = 4'd0;
  localparam logic [HDR_CNT_W-1:0] HDR_TYPE_POS  = 4'd1;
  localparam logic [HDR_CNT_W-1:0] HDR_LEN_POS   = 4'd10;
  localparam logic [HDR_CNT_W-1:0] HDR_LAST_POS  = 4'(HDR_BYTES - 1);

  // Field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ID_W   = 64;
  localparam int unsigned LEN_W  = 32;
  localparam int unsigned DATA_W = BYTE_W + ID_W + LEN_W + BYTE_W;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_MAGIC = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_MASK   = 8'd1;
  localparam logic [BYTE_W-1:0] FRAME_MAGIC_RST = 8'h00;
  localparam logic [BYTE_W-1:0] TYPE_MASK_RST   = 8'hFF;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_EMPTY = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_ERROR = 2'd2
  } result_kind_t;

  // One result item
  typedef struct packed {
    result_kind_t        result_kind;
    logic [BYTE_W-1:0]   frame_type;
    logic [ID_W-1:0]     stream_ident;
    logic [LEN_W-1:0]    frame_length;
    logic [BYTE_W-1:0]   payload_byte;
    logic                last_of_frame;
  } result_t;

endpackage

>>> rtl/core/lpfp_parse.sv
// Frame parsing engine: header deframing, payload counting and error latch.
// Depends on lpfp_pkg; one byte is consumed per step with the result in the same cycle.
module lpfp_parse import lpfp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic [BYTE_W-1:0] frame_magic,
  input  logic [BYTE_W-1:0] type_mask,
  output logic              res_valid,
  output result_t           res
);

  logic                 channel_closed, channel_closed_next;
  logic                 in_payload, in_payload_next;
  logic [HDR_CNT_W-1:0] header_count, header_count_next;
  logic                 magic_bad, magic_bad_next;
  logic [BYTE_W-1:0]    frame_type_reg, frame_type_reg_next;
  logic [ID_W-1:0]      stream_id_reg, stream_id_reg_next;
  logic [LEN_W-1:0]     payload_len_reg, payload_len_reg_next;
  logic [LEN_W-1:0]     payload_remaining, payload_remaining_next;
  logic                 last_byte;

  assign last_byte = (payload_remaining <= LEN_W'(1));

  // Decode one byte: update state and form the result
  always_comb begin
    channel_closed_next    = channel_closed;
    in_payload_next        = in_payload;
    header_count_next      = header_count;
    magic_bad_next         = magic_bad;
    frame_type_reg_next    = frame_type_reg;
    stream_id_reg_next     = stream_id_reg;
    payload_len_reg_next   = payload_len_reg;
    payload_remaining_next = payload_remaining;
    res_valid              = 1'b0;
    res                    = '0;

    if (step && !channel_closed) begin
      if (in_payload) begin
        res_valid         = 1'b1;
        res.result_kind   = KIND_DATA;
        res.frame_type    = frame_type_reg & type_mask;
        res.stream_ident  = stream_id_reg;
        res.frame_length  = payload_len_reg;
        res.payload_byte  = in_byte;
        res.last_of_frame = last_byte;
        if (last_byte) begin
          payload_remaining_next = '0;
          in_payload_next        = 1'b0;
        end else begin
          payload_remaining_next = payload_remaining - LEN_W'(1);
        end
      end else begin
        // Shift the byte into its header field
        if (header_count == HDR_MAGIC_POS) begin
          magic_bad_next = (in_byte != frame_magic);
        end else if (header_count == HDR_TYPE_POS) begin
          frame_type_reg_next = in_byte;
        end else if (header_count < HDR_LEN_POS) begin
          stream_id_reg_next = {stream_id_reg[ID_W-BYTE_W-1:0], in_byte};
        end else begin
          payload_len_reg_next = {payload_len_reg[LEN_W-BYTE_W-1:0], in_byte};
        end

        if (header_count != HDR_LAST_POS) begin
          header_count_next = header_count + HDR_CNT_W'(1);
        end else begin
          // Header complete: close on bad magic, else finish or open payload
          header_count_next = '0;
          if (magic_bad) begin
            channel_closed_next = 1'b1;
            res_valid           = 1'b1;
            res.result_kind     = KIND_ERROR;
          end else if (payload_len_reg_next == '0) begin
            res_valid         = 1'b1;
            res.result_kind   = KIND_EMPTY;
            res.frame_type    = frame_type_reg & type_mask;
            res.stream_ident  = stream_id_reg;
            res.last_of_frame = 1'b1;
          end else begin
            in_payload_next        = 1'b1;
            payload_remaining_next = payload_len_reg_next;
          end
        end
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_closed    <= 1'b0;
      in_payload        <= 1'b0;
      header_count      <= '0;
      magic_bad         <= 1'b0;
      frame_type_reg    <= '0;
      stream_id_reg     <= '0;
      payload_len_reg   <= '0;
      payload_remaining <= '0;
    end else begin
      channel_closed    <= channel_closed_next;
      in_payload        <= in_payload_next;
      header_count      <= header_count_next;
      magic_bad         <= magic_bad_next;
      frame_type_reg    <= frame_type_reg_next;
      stream_id_reg     <= stream_id_reg_next;
      payload_len_reg   <= payload_len_reg_next;
      payload_remaining <= payload_remaining_next;
    end
  end

endmodule

>>> rtl/core/length_prefixed_frame_parser.sv
// Top level of the length-prefixed frame parser: stream ports, config registers,
// input and result registers. Depends on lpfp_pkg and lpfp_parse.
//
// The parser takes one received byte per cycle while m_tready is high, with no gaps
// between frames. Each frame opens with a 14-byte header (magic, flags, 64-bit
// big-endian stream id, 32-bit big-endian length); header bytes give no result, each
// payload byte gives one result, an empty frame gives one completion, and a bad magic
// byte gives one error on the last header byte and closes the channel until reset.
// The byte waits in the input register, the parse logic runs between that register
// and the result register, and the result waits there until m_tready. Throughput
// is one byte per cycle while m_tready is high. Configuration writes are taken at
// any time but must only be issued while the parser is idle.
module length_prefixed_frame_parser import lpfp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // Input byte stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] in_byte
  // Result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [DATA_W-1:0]    m_tdata,   // [7:0] frame_type, [71:8] stream_ident,
                                          // [103:72] frame_length, [111:104] payload_byte
  output logic                 m_tlast,   // last_of_frame
  output logic [1:0]           m_tuser,   // [1:0] result_kind
  // Configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  logic [BYTE_W-1:0] frame_magic;
  logic [BYTE_W-1:0] type_mask;
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              advance;
  logic              res_valid;
  result_t           res;
  result_t           out_res;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_magic <= FRAME_MAGIC_RST;
      type_mask   <= TYPE_MASK_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_MAGIC: frame_magic <= cfg_data;
        REG_TYPE_MASK:   type_mask   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Move the held byte on when the result register is free or being drained
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  lpfp_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .in_byte     (in_byte),
    .frame_magic (frame_magic),
    .type_mask   (type_mask),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && (!m_tvalid || m_tready)) begin
      out_res <= res;
    end
  end

  assign m_tdata = {out_res.payload_byte, out_res.frame_length,
                    out_res.stream_ident, out_res.frame_type};
  assign m_tlast = out_res.last_of_frame;
  assign m_tuser = out_res.result_kind;

endmodule

>>> rtl/core/lpfp_checker.sv
// Port-level checks for the length-prefixed frame parser, bound to the top level.
// Depends on lpfp_pkg and length_prefixed_frame_parser.
module lpfp_port_checks import lpfp_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [DATA_W-1:0] m_tdata,
  input logic              m_tlast,
  input logic [1:0]        m_tuser
);

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  // Report only defined result kinds
  a_kind_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == KIND_EMPTY || m_tuser == KIND_DATA
      || m_tuser == KIND_ERROR))
    else $error("undefined result kind");

  // Send an error with all fields cleared
  a_error_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_ERROR |-> m_tdata == '0 && !m_tlast)
    else $error("error result carries data");

  // Mark an empty frame as last with zero length and no data byte
  a_empty_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_EMPTY |->
      m_tlast && m_tdata[DATA_W-1:DATA_W-BYTE_W] == '0
      && m_tdata[DATA_W-BYTE_W-1:BYTE_W+ID_W] == '0)
    else $error("malformed empty-frame completion");

  // Stay silent once an error has been delivered
  a_closed_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tuser == KIND_ERROR |=> !m_tvalid)
    else $error("result after channel closed");

endmodule

bind length_prefixed_frame_parser lpfp_port_checks u_lpfp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

>>> test/lpfp_checker.sv
// Watches the byte, result and register channels of the frame parser, predicts every result
// and compares it with what comes out. Depends on lpfp_pkg; instantiated by the testbench top.
module lpfp_checker import lpfp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [BYTE_W-1:0]    s_tdata,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [DATA_W-1:0]    m_tdata,
  input  logic                 m_tlast,
  input  logic [1:0]           m_tuser,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  output int                   pending,
  output int                   mismatches,
  output int                   results_checked
);

  localparam int REPORT_MAX = 10;
  // Bit offsets of the result fields in m_tdata
  localparam int TYPE_LSB = 0;
  localparam int ID_LSB   = TYPE_LSB + BYTE_W;
  localparam int LEN_LSB  = ID_LSB + ID_W;
  localparam int PAY_LSB  = LEN_LSB + LEN_W;

  // Register copies
  logic [BYTE_W-1:0] magic_cfg;
  logic [BYTE_W-1:0] mask_cfg;

  // Deframer state
  logic                 link_closed;
  logic                 in_body;
  logic                 magic_miss;
  logic [HDR_CNT_W-1:0] hdr_pos;
  logic [BYTE_W-1:0]    flags_raw;
  logic [ID_W-1:0]      id_acc;
  logic [LEN_W-1:0]     len_acc;
  logic [LEN_W-1:0]     body_left;

  result_t due_results[$];
  int      fail_count = 0;

  // Advance the deframer by one received byte and queue the result it causes
  task automatic deframe_byte(input logic [BYTE_W-1:0] b);
    result_t r;
    r = '0;
    if (link_closed) return;

    // Payload byte: pass it out with the header fields
    if (in_body) begin
      r.result_kind   = KIND_DATA;
      r.frame_type    = flags_raw & mask_cfg;
      r.stream_ident  = id_acc;
      r.frame_length  = len_acc;
      r.payload_byte  = b;
      r.last_of_frame = (body_left <= 1);
      due_results.push_back(r);
      if (body_left <= 1) begin
        body_left = '0;
        in_body   = 1'b0;
      end else begin
        body_left = body_left - 1;
      end
      return;
    end

    // Header byte: shift it into its field
    if (hdr_pos == HDR_MAGIC_POS) begin
      magic_miss = (b != magic_cfg);
    end else if (hdr_pos == HDR_TYPE_POS) begin
      flags_raw = b;
    end else if (hdr_pos < HDR_LEN_POS) begin
      id_acc = {id_acc[ID_W-BYTE_W-1:0], b};
    end else begin
      len_acc = {len_acc[LEN_W-BYTE_W-1:0], b};
    end

    if (hdr_pos != HDR_LAST_POS) begin
      hdr_pos = hdr_pos + 1'b1;
      return;
    end
    hdr_pos = '0;

    // Header complete: error closes the link, empty frame completes at once
    if (magic_miss) begin
      link_closed   = 1'b1;
      r.result_kind = KIND_ERROR;
      due_results.push_back(r);
    end else if (len_acc == '0) begin
      r.result_kind   = KIND_EMPTY;
      r.frame_type    = flags_raw & mask_cfg;
      r.stream_ident  = id_acc;
      r.last_of_frame = 1'b1;
      due_results.push_back(r);
    end else begin
      in_body   = 1'b1;
      body_left = len_acc;
    end
  endtask

  // Count a bad result and show the first few
  task automatic flag_result(input string what, input result_t want, input result_t got);
    if (fail_count < REPORT_MAX) begin
      $display("[%0t] %s: want kind=%0d type=%h id=%h len=%h data=%h last=%b",
               $realtime, what, want.result_kind, want.frame_type, want.stream_ident,
               want.frame_length, want.payload_byte, want.last_of_frame);
      $display("        got  kind=%0d type=%h id=%h len=%h data=%h last=%b",
               got.result_kind, got.frame_type, got.stream_ident,
               got.frame_length, got.payload_byte, got.last_of_frame);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst) begin
      magic_cfg   = FRAME_MAGIC_RST;
      mask_cfg    = TYPE_MASK_RST;
      link_closed = 1'b0;
      in_body     = 1'b0;
      magic_miss  = 1'b0;
      hdr_pos     = '0;
      flags_raw   = '0;
      id_acc      = '0;
      len_acc     = '0;
      body_left   = '0;
      due_results.delete();
    end else begin
      // Compare each result request with the oldest prediction
      if (m_tvalid && m_tready) begin
        got.result_kind   = result_kind_t'(m_tuser);
        got.frame_type    = m_tdata[TYPE_LSB +: BYTE_W];
        got.stream_ident  = m_tdata[ID_LSB +: ID_W];
        got.frame_length  = m_tdata[LEN_LSB +: LEN_W];
        got.payload_byte  = m_tdata[PAY_LSB +: BYTE_W];
        got.last_of_frame = m_tlast;
        results_checked <= results_checked + 1;
        if (due_results.size() == 0) begin
          flag_result("unexpected result", '0, got);
        end else begin
          want = due_results.pop_front();
          if (got !== want) flag_result("result mismatch", want, got);
        end
      end
      // Predict from each accepted byte request
      if (s_tvalid && s_tready) deframe_byte(s_tdata);
      // Track register writes; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_MAGIC: magic_cfg = cfg_data;
          REG_TYPE_MASK:   mask_cfg  = cfg_data;
          default: ;
        endcase
      end
    end
    pending    <= due_results.size();
    mismatches <= fail_count;
  end

endmodule

>>> test/tb_length_prefixed_frame_parser.sv
// Testbench top for the length-prefixed frame parser: clock, reset, byte and register stimulus,
// random result back-pressure and the verdict. Depends on lpfp_pkg, lpfp_checker and the RTL.
module tb_length_prefixed_frame_parser;
  import lpfp_pkg::*;

  localparam int unsigned RANDOM_BYTES = 1500;
  localparam int unsigned RETUNE_EVERY = 150;
  localparam int unsigned SETTLE       = 4;
  localparam int unsigned DRAIN_LIMIT  = 2000;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hFF;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [BYTE_W-1:0]    s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [DATA_W-1:0]    m_tdata;
  logic                 m_tlast;
  logic [1:0]           m_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_data;

  int pending;
  int mismatches;
  int results_checked;

  // Stimulus bookkeeping
  bit                quiet = 1'b0;
  logic [BYTE_W-1:0] magic_now = FRAME_MAGIC_RST;
  int unsigned       bytes_sent = 0;
  int unsigned       frames_sent = 0;
  int unsigned       cfg_writes = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  length_prefixed_frame_parser u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lpfp_checker u_chk (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tlast         (m_tlast),
    .m_tuser         (m_tuser),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .pending         (pending),
    .mismatches      (mismatches),
    .results_checked (results_checked)
  );

  // Idle cycles before a request; none during quiet stretches
  function automatic int unsigned draw_gap();
    return quiet ? 0 : $urandom_range(0, 6);
  endfunction

  // Register value biased toward the extremes
  function automatic logic [BYTE_W-1:0] pick_setting();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  // Offer one byte and hold it until the parser takes the request
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  // Drain the parser, then write one register
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_FRAME_MAGIC) magic_now = val;
    cfg_writes++;
  endtask

  // Send a whole frame; shuffle gives random payload and register writes mid-frame
  task automatic send_frame(input logic [BYTE_W-1:0] flags, input logic [ID_W-1:0] id,
                            input logic [LEN_W-1:0] len, input bit good_magic,
                            input bit shuffle);
    logic [BYTE_W-1:0] pay;
    send_byte(good_magic ? magic_now : magic_now + 8'd1);
    if (shuffle && $urandom_range(0, 24) == 0) write_reg(REG_FRAME_MAGIC, pick_setting());
    send_byte(flags);
    for (int k = ID_W / BYTE_W - 1; k >= 0; k--) send_byte(id[BYTE_W*k +: BYTE_W]);
    for (int k = LEN_W / BYTE_W - 1; k >= 0; k--) send_byte(len[BYTE_W*k +: BYTE_W]);
    for (longint unsigned i = 0; i < len; i++) begin
      if (shuffle && i != 0 && $urandom_range(0, 59) == 0)
        write_reg(REG_TYPE_MASK, pick_setting());
      pay = shuffle ? BYTE_W'($urandom) : (i[0] ? 8'hFF : 8'h00);
      send_byte(pay);
    end
    frames_sent++;
  endtask

  // Result side: stall at random before each request
  initial begin : sink
    int unsigned stall;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin : stimulus
    int unsigned       r;
    int unsigned       next_retune;
    int unsigned       stop_at;
    int unsigned       waited;
    int                leftover;
    logic [LEN_W-1:0]  len;

    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: unused register index, empty frame with all-ones flags and id under reset
    // settings, then an extreme magic, a zero mask and a short frame with extreme payload
    write_reg(REG_UNUSED, 8'h5A);
    send_frame(8'hFF, '1, '0, 1'b1, 1'b0);
    write_reg(REG_FRAME_MAGIC, 8'hFF);
    write_reg(REG_TYPE_MASK, 8'h00);
    send_frame(8'hA5, 64'h0123_4567_89AB_CDEF, 32'd2, 1'b1, 1'b0);

    // Random well-formed frames, retuning both registers now and then
    stop_at     = bytes_sent + RANDOM_BYTES;
    next_retune = bytes_sent;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) quiet = !quiet;
      if (bytes_sent >= next_retune) begin
        write_reg(REG_FRAME_MAGIC, pick_setting());
        write_reg(REG_TYPE_MASK, pick_setting());
        next_retune = bytes_sent + RETUNE_EVERY;
      end
      r = $urandom_range(0, 99);
      if (r < 12)      len = '0;
      else if (r < 20) len = 32'd1;
      else if (r < 96) len = $urandom_range(2, 14);
      else             len = $urandom_range(200, 300);
      send_frame(BYTE_W'($urandom), {$urandom, $urandom}, len, 1'b1, 1'b1);
    end

    // Bad magic closes the link; the payload that follows must be dropped
    quiet = 1'b0;
    write_reg(REG_FRAME_MAGIC, pick_setting());
    send_frame(BYTE_W'($urandom), {$urandom, $urandom}, 32'd6, 1'b0, 1'b1);

    // Drain and judge
    s_tvalid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    leftover = pending;
    if (leftover != 0) $display("%0d predicted results never came out", leftover);

    $display("Covered %0d bytes in %0d frames with %0d register writes; %0d results checked,",
             bytes_sent, frames_sent, cfg_writes, results_checked);
    $display("ending with a bad-magic header that closes the link.");
    if (mismatches == 0 && leftover == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop if the handshakes hang
  initial begin : watchdog
    #(20 * CYCLE_LIMIT);
    $display("Timed out waiting on the parser");
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/lpfp_pkg.sv
rtl/core/lpfp_parse.sv
rtl/core/length_prefixed_frame_parser.sv
rtl/core/lpfp_checker.sv
test/lpfp_checker.sv
test/tb_length_prefixed_frame_parser.sv
